@@ rtl/opsr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// opsr_pkg: shared types and codes for the object pool
// Payload words, command and status codes, and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package opsr_pkg;

  localparam int unsigned POOL_SIZE_DEF    = 64;
  localparam int unsigned PENDING_SIZE_DEF = 64;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned EID_W     = 6;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CNT_OUT_W = 7;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COLLECT = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [EID_W-1:0] entry_id;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [EID_W-1:0]     granted_id;
    logic [CNT_OUT_W-1:0] released_count;
    logic [CNT_OUT_W-1:0] active_count;
    logic [CNT_OUT_W-1:0] free_count;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic init_step;
    logic latch_item;
    logic exec;
    logic acq_commit;
    logic col_take_id;
    logic col_check;
    logic col_free;
    logic col_move;
    logic col_next;
    logic load_result;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic             init_last;
    logic [CMD_W-1:0] cmd;
    logic             acq_blocked;
    logic             pend_empty;
    logic             pos_hit;
    logic             can_free;
    logic             pos_is_last;
    logic             idx_last;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/opsr_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// opsr_if: request and response channels of the object pool
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface opsr_cmd_if import opsr_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface opsr_rsp_if import opsr_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/object_pool_swap_remove.sv @@
`default_nettype none
// Sequence: acquire goes through exec, the acquire commit and done; mark and unused
//   codes go through exec and done; collect walks each pending mark through position
//   read and active check, then free, and a move when the hole takes the last active entry.
// Throughput: one word at a time; a result still waiting in the output register
//   holds the next one in its done state.
// Reset: async; an init pass then fills the tables, request not ready.
// ----------------------------------------------------------------------------
// object_pool_swap_remove: pool of numbered entries with swap-remove release
// Controller plus datapath; LIFO free stack, dense active list, per-entry
// position table and a pending-release queue drained by collect.
// ----------------------------------------------------------------------------
module object_pool_swap_remove import opsr_pkg::*; #(
  parameter int unsigned POOL_SIZE    = POOL_SIZE_DEF,
  parameter int unsigned PENDING_SIZE = PENDING_SIZE_DEF
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  opsr_cmd_if.sink   in_i,
  opsr_rsp_if.source out_o
);

  ctl_cmd_t ctl;
  dp_stat_t stat;
  rsp_t     rsp;
  logic     in_ready;
  logic     out_valid;

  opsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  opsr_dpath #(
    .POOL_SIZE    (POOL_SIZE),
    .PENDING_SIZE (PENDING_SIZE)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (in_i.data),
    .ctl_i  (ctl),
    .stat_o (stat),
    .rsp_o  (rsp)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = rsp;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request taken while a word is in flight");

  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      CNT_OUT_W'(out_o.data.active_count + out_o.data.free_count) == CNT_OUT_W'(POOL_SIZE))
    else $error("active and free counts do not cover the pool");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.status == ST_EMPTY) |->
      (out_o.data.free_count == '0 && out_o.data.granted_id == '0))
    else $error("empty status with free entries or a grant");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.status == ST_FULL) |->
      (out_o.data.released_count == '0 && out_o.data.granted_id == '0))
    else $error("queue-full status with a grant or release");
`endif

endmodule
`default_nettype wire

@@ rtl/opsr_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// opsr_dpath: object pool datapath
// Free stack, active list, position table and pending queue memories, the
// depth counters, the collect walk index and the result register.
// ----------------------------------------------------------------------------
module opsr_dpath import opsr_pkg::*; #(
  parameter int unsigned POOL_SIZE    = POOL_SIZE_DEF,
  parameter int unsigned PENDING_SIZE = PENDING_SIZE_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cmd_t     item_i,
  input  wire ctl_cmd_t ctl_i,
  output dp_stat_t      stat_o,
  output rsp_t          rsp_o
);

  localparam int unsigned ID_W  = $clog2(POOL_SIZE);
  localparam int unsigned CNT_W = $clog2(POOL_SIZE + 1);
  localparam int unsigned PQ_AW = (PENDING_SIZE > 1) ? $clog2(PENDING_SIZE) : 1;
  localparam int unsigned PQ_CW = $clog2(PENDING_SIZE + 1);
  localparam int unsigned CMP_W = (EID_W > CNT_W) ? EID_W : CNT_W;

  localparam logic [CNT_W-1:0] POOL_CNT  = CNT_W'(POOL_SIZE);
  localparam logic [PQ_CW-1:0] PEND_CNT  = PQ_CW'(PENDING_SIZE);
  localparam logic [ID_W-1:0]  POOL_LAST = ID_W'(POOL_SIZE - 1);
  localparam logic [CMP_W-1:0] POOL_CMP  = CMP_W'(POOL_SIZE);

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] pos;
  } pos_ent_t;

  // memories
  logic [ID_W-1:0]  fs_mem [POOL_SIZE];
  logic [ID_W-1:0]  al_mem [POOL_SIZE];
  pos_ent_t         pm_mem [POOL_SIZE];
  logic [EID_W-1:0] pq_mem [PENDING_SIZE];

  logic [ID_W-1:0]  fs_rd_q;
  logic [ID_W-1:0]  al_rd0_q;
  logic [ID_W-1:0]  al_rd1_q;
  pos_ent_t         pm_rd_q;
  logic [EID_W-1:0] pq_rd_q;

  // control state
  logic [CNT_W-1:0] free_depth_q;
  logic [CNT_W-1:0] active_depth_q;
  logic [PQ_CW-1:0] pend_depth_q;
  logic [PQ_CW-1:0] idx_q, idx_d;
  logic [ID_W-1:0]  init_q;

  // item and walk payload
  logic [CMD_W-1:0]  cmd_q;
  logic [EID_W-1:0]  eid_q;
  logic [STAT_W-1:0] status_q;
  logic [ID_W-1:0]   granted_q;
  logic [CNT_W-1:0]  released_q;
  logic [ID_W-1:0]   cur_id_q;
  logic              id_ok_q;
  logic [ID_W-1:0]   cur_pos_q;
  logic [ID_W-1:0]   mover_q;
  rsp_t              rsp_q;

  logic             acq_blocked, pend_full, pend_empty, free_full;
  logic             pos_hit, can_free, pos_is_last, idx_last, q_id_ok;
  logic [CNT_W-1:0] last_pos;
  logic             mark_wr;

  logic             al_we;
  logic [ID_W-1:0]  al_wa, al_wd;
  logic             pm_we;
  logic [ID_W-1:0]  pm_wa;
  pos_ent_t         pm_wd;

  assign acq_blocked = (free_depth_q == '0) || (active_depth_q >= POOL_CNT);
  assign pend_full   = pend_depth_q >= PEND_CNT;
  assign pend_empty  = pend_depth_q == '0;
  assign free_full   = free_depth_q >= POOL_CNT;
  assign last_pos    = active_depth_q - 1'b1;
  assign pos_hit     = id_ok_q && pm_rd_q.valid && (CNT_W'(pm_rd_q.pos) < active_depth_q);
  assign can_free    = (al_rd0_q == cur_id_q) && !free_full;
  assign pos_is_last = CNT_W'(cur_pos_q) == last_pos;
  assign idx_last    = PQ_CW'(idx_q + 1'b1) == pend_depth_q;
  assign q_id_ok     = CMP_W'(pq_rd_q) < POOL_CMP;
  assign mark_wr     = ctl_i.exec && (cmd_q == CMD_MARK) && !pend_full;

  always_comb begin
    idx_d = idx_q;
    if (ctl_i.col_next) begin
      idx_d = idx_last ? '0 : PQ_CW'(idx_q + 1'b1);
    end
  end

  // active list write port
  always_comb begin
    al_we = 1'b0;
    al_wa = init_q;
    al_wd = init_q;
    if (ctl_i.init_step) begin
      al_we = 1'b1;
    end else if (ctl_i.acq_commit) begin
      al_we = 1'b1;
      al_wa = active_depth_q[ID_W-1:0];
      al_wd = fs_rd_q;
    end else if (ctl_i.col_free && !pos_is_last) begin
      // last active entry fills the hole
      al_we = 1'b1;
      al_wa = cur_pos_q;
      al_wd = al_rd1_q;
    end
  end

  // position table write port
  always_comb begin
    pm_we = 1'b0;
    pm_wa = init_q;
    pm_wd = '{valid: 1'b1, pos: init_q};
    if (ctl_i.init_step) begin
      pm_we = 1'b1;
    end else if (ctl_i.acq_commit) begin
      pm_we = 1'b1;
      pm_wa = fs_rd_q;
      pm_wd = '{valid: 1'b1, pos: active_depth_q[ID_W-1:0]};
    end else if (ctl_i.col_free) begin
      pm_we = 1'b1;
      pm_wa = cur_id_q;
      pm_wd = '0;
    end else if (ctl_i.col_move) begin
      pm_we = 1'b1;
      pm_wa = mover_q;
      pm_wd = '{valid: 1'b1, pos: cur_pos_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.col_free) begin
      fs_mem[free_depth_q[ID_W-1:0]] <= cur_id_q;
    end
    fs_rd_q <= fs_mem[ID_W'(free_depth_q - 1'b1)];
  end

  always_ff @(posedge clk_i) begin
    if (al_we) begin
      al_mem[al_wa] <= al_wd;
    end
    al_rd0_q <= al_mem[pm_rd_q.pos];
    al_rd1_q <= al_mem[ID_W'(last_pos)];
  end

  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      pm_mem[pm_wa] <= pm_wd;
    end
    pm_rd_q <= pm_mem[ID_W'(pq_rd_q)];
  end

  always_ff @(posedge clk_i) begin
    if (mark_wr) begin
      pq_mem[pend_depth_q[PQ_AW-1:0]] <= eid_q;
    end
    pq_rd_q <= pq_mem[idx_d[PQ_AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_depth_q   <= '0;
      active_depth_q <= POOL_CNT;
      pend_depth_q   <= '0;
      idx_q          <= '0;
      init_q         <= '0;
    end else begin
      idx_q <= idx_d;
      if (ctl_i.init_step) begin
        init_q <= ID_W'(init_q + 1'b1);
      end
      if (mark_wr) begin
        pend_depth_q <= PQ_CW'(pend_depth_q + 1'b1);
      end else if (ctl_i.col_next && idx_last) begin
        pend_depth_q <= '0;
      end
      if (ctl_i.acq_commit) begin
        free_depth_q   <= free_depth_q - 1'b1;
        active_depth_q <= active_depth_q + 1'b1;
      end else if (ctl_i.col_free) begin
        free_depth_q   <= free_depth_q + 1'b1;
        active_depth_q <= active_depth_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch_item) begin
      cmd_q      <= item_i.command;
      eid_q      <= item_i.entry_id;
      status_q   <= ST_OK;
      granted_q  <= '0;
      released_q <= '0;
    end
    if (ctl_i.exec) begin
      if (cmd_q == CMD_ACQUIRE && acq_blocked) begin
        status_q <= ST_EMPTY;
      end else if (cmd_q == CMD_MARK && pend_full) begin
        status_q <= ST_FULL;
      end
    end
    if (ctl_i.acq_commit) begin
      granted_q <= fs_rd_q;
    end
    if (ctl_i.col_take_id) begin
      cur_id_q <= ID_W'(pq_rd_q);
      id_ok_q  <= q_id_ok;
    end
    if (ctl_i.col_check) begin
      cur_pos_q <= pm_rd_q.pos;
    end
    if (ctl_i.col_free) begin
      mover_q    <= al_rd1_q;
      released_q <= released_q + 1'b1;
    end
    if (ctl_i.load_result) begin
      rsp_q.status         <= status_q;
      rsp_q.granted_id     <= EID_W'(granted_q);
      rsp_q.released_count <= CNT_OUT_W'(released_q);
      rsp_q.active_count   <= CNT_OUT_W'(active_depth_q);
      rsp_q.free_count     <= CNT_OUT_W'(free_depth_q);
    end
  end

  assign stat_o.init_last   = init_q == POOL_LAST;
  assign stat_o.cmd         = cmd_q;
  assign stat_o.acq_blocked = acq_blocked;
  assign stat_o.pend_empty  = pend_empty;
  assign stat_o.pos_hit     = pos_hit;
  assign stat_o.can_free    = can_free;
  assign stat_o.pos_is_last = pos_is_last;
  assign stat_o.idx_last    = idx_last;

  assign rsp_o = rsp_q;

endmodule
`default_nettype wire

@@ rtl/opsr_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// opsr_ctrl: object pool controller
// Sequences the init pass, acquire, mark and the collect walk, and owns the
// request ready and the response valid.
// ----------------------------------------------------------------------------
module opsr_ctrl import opsr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire dp_stat_t stat_i,
  output ctl_cmd_t      ctl_o
);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_EXEC  = 9'b000000100,
    S_ACQ   = 9'b000001000,
    S_CPOS  = 9'b000010000,
    S_CACT  = 9'b000100000,
    S_CFREE = 9'b001000000,
    S_CMOVE = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e   state_q, state_d;
  logic     out_valid_q;
  state_e   walk_next;

  assign walk_next = stat_i.idx_last ? S_DONE : S_CPOS;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_INIT: begin
        ctl_o.init_step = 1'b1;
        if (stat_i.init_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.latch_item = 1'b1;
          state_d          = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl_o.exec = 1'b1;
        if (stat_i.cmd == CMD_ACQUIRE && !stat_i.acq_blocked) begin
          state_d = S_ACQ;
        end else if (stat_i.cmd == CMD_COLLECT && !stat_i.pend_empty) begin
          state_d = S_CPOS;
        end else begin
          state_d = S_DONE;
        end
      end
      S_ACQ: begin
        ctl_o.acq_commit = 1'b1;
        state_d          = S_DONE;
      end
      S_CPOS: begin
        ctl_o.col_take_id = 1'b1;
        state_d           = S_CACT;
      end
      S_CACT: begin
        ctl_o.col_check = 1'b1;
        if (stat_i.pos_hit) begin
          state_d = S_CFREE;
        end else begin
          // stale or out-of-range mark: skip it
          ctl_o.col_next = 1'b1;
          state_d        = walk_next;
        end
      end
      S_CFREE: begin
        ctl_o.col_free = stat_i.can_free;
        if (!stat_i.can_free || stat_i.pos_is_last) begin
          ctl_o.col_next = 1'b1;
          state_d        = walk_next;
        end else begin
          state_d = S_CMOVE;
        end
      end
      S_CMOVE: begin
        ctl_o.col_move = 1'b1;
        ctl_o.col_next = 1'b1;
        state_d        = walk_next;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          ctl_o.load_result = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctl_o.load_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

@@ dv/object_pool_swap_remove_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// object_pool_swap_remove_tb: self-checking bench for the object pool
// Drives acquire, mark and collect words through the request channel with
// random gaps and response stalls. A scoreboard class keeps its own pool
// state, works out every response and compares it field by field.
// ----------------------------------------------------------------------------
module object_pool_swap_remove_tb;
  import opsr_pkg::*;

  localparam int unsigned      NUM_ENTRIES  = POOL_SIZE_DEF;
  localparam int unsigned      QUEUE_SLOTS  = PENDING_SIZE_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
  localparam int unsigned      RANDOM_ITEMS = 400;
  localparam int unsigned      CYCLE_LIMIT  = 1000000;
  localparam int unsigned      DRAIN_CYCLES = 300;

  // --------------------------------------------------------------------------
  // Scoreboard: private copy of the pool and the responses still owed
  // --------------------------------------------------------------------------
  class pool_scoreboard;
    logic [EID_W-1:0] free_stack [NUM_ENTRIES];
    int unsigned      free_depth;
    logic [EID_W-1:0] active_list[NUM_ENTRIES];
    int unsigned      active_depth;
    int unsigned      slot_of    [NUM_ENTRIES];
    bit               slot_valid [NUM_ENTRIES];
    logic [EID_W-1:0] release_q  [QUEUE_SLOTS];
    int unsigned      release_depth;
    rsp_t             owed_q[$];
    int unsigned      errors;

    function new();
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        free_stack[i]  = '0;
        active_list[i] = EID_W'(i);
        slot_of[i]     = i;
        slot_valid[i]  = 1'b1;
      end
      for (int i = 0; i < QUEUE_SLOTS; i++) release_q[i] = '0;
      free_depth    = 0;
      active_depth  = NUM_ENTRIES;
      release_depth = 0;
      errors        = 0;
    endfunction

    function int unsigned outstanding();
      return owed_q.size();
    endfunction

    // Free one entry with swap-remove; skip stale, duplicate or unknown ids.
    function int unsigned try_free(int unsigned id);
      int unsigned pos;
      int unsigned last;
      int unsigned mover;
      if (id >= NUM_ENTRIES || !slot_valid[id]) return 0;
      pos = slot_of[id];
      if (pos >= active_depth || active_list[pos] != id) return 0;
      if (free_depth >= NUM_ENTRIES) return 0;
      free_stack[free_depth] = EID_W'(id);
      free_depth++;
      slot_valid[id] = 1'b0;
      slot_of[id]    = 0;
      last = active_depth - 1;
      if (pos != last) begin
        mover = active_list[last];
        active_list[pos] = EID_W'(mover);
        if (mover < NUM_ENTRIES) begin
          slot_of[mover]    = pos;
          slot_valid[mover] = 1'b1;
        end
      end
      active_depth = last;
      return 1;
    endfunction

    function void note_cmd(cmd_t w);
      rsp_t        r;
      int unsigned id;
      int unsigned freed;
      r = '0;
      freed = 0;
      case (w.command)
        CMD_ACQUIRE: begin
          if (free_depth == 0 || active_depth >= NUM_ENTRIES) begin
            r.status = ST_EMPTY;
          end else begin
            free_depth--;
            id = free_stack[free_depth];
            if (id < NUM_ENTRIES) begin
              slot_of[id]    = active_depth;
              slot_valid[id] = 1'b1;
            end
            active_list[active_depth] = EID_W'(id);
            active_depth++;
            r.granted_id = EID_W'(id);
          end
        end
        CMD_MARK: begin
          if (release_depth >= QUEUE_SLOTS) begin
            r.status = ST_FULL;
          end else begin
            release_q[release_depth] = w.entry_id;
            release_depth++;
          end
        end
        CMD_COLLECT: begin
          for (int i = 0; i < release_depth && i < QUEUE_SLOTS; i++)
            freed += try_free(release_q[i]);
          release_depth = 0;
        end
        default: ;
      endcase
      r.released_count = CNT_OUT_W'(freed);
      r.active_count   = CNT_OUT_W'(active_depth);
      r.free_count     = CNT_OUT_W'(free_depth);
      owed_q = {owed_q, r};
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_rsp(rsp_t got);
      rsp_t want;
      if (owed_q.size() == 0) begin
        report_mismatch("unexpected response word, owed", 1, 0);
      end else begin
        want = owed_q.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
        if (got.granted_id !== want.granted_id)
          report_mismatch("granted_id", got.granted_id, want.granted_id);
        if (got.released_count !== want.released_count)
          report_mismatch("released_count", got.released_count, want.released_count);
        if (got.active_count !== want.active_count)
          report_mismatch("active_count", got.active_count, want.active_count);
        if (got.free_count !== want.free_count)
          report_mismatch("free_count", got.free_count, want.free_count);
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;

  opsr_cmd_if cmd_ch ();
  opsr_rsp_if rsp_ch ();

  object_pool_swap_remove uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (rsp_ch)
  );

  pool_scoreboard sb = new();
  bit             calm;
  int unsigned    words_sent;
  int unsigned    cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones; none while calm.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Response side: stall stretches alternating with ready stretches.
  initial begin
    int unsigned stall;
    int unsigned hold;
    rsp_ch.ready = 1'b0;
    forever begin
      stall = pick_gap();
      hold  = $urandom_range(1, 8);
      repeat (stall) begin
        @(negedge clk_i);
        rsp_ch.ready <= 1'b0;
      end
      repeat (hold) begin
        @(negedge clk_i);
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      sb.check_rsp(rsp_ch.data);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[object_pool_swap_remove] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  task automatic send_word(logic [CMD_W-1:0] command, logic [EID_W-1:0] id);
    cmd_t        w;
    int unsigned gap;
    w.command  = command;
    w.entry_id = id;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= w;
    do @(posedge clk_i); while (cmd_ch.ready !== 1'b1);
    sb.note_cmd(w);
    words_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    cmd_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // Mostly a live entry, now and then any id (stale or duplicate).
  function automatic logic [EID_W-1:0] pick_victim();
    if (sb.active_depth == 0 || $urandom_range(0, 9) == 0)
      return EID_W'($urandom_range(0, NUM_ENTRIES - 1));
    return sb.active_list[$urandom_range(0, sb.active_depth - 1)];
  endfunction

  task automatic release_round();
    int unsigned k;
    logic [EID_W-1:0] id;
    k = $urandom_range(1, 8);
    for (int i = 0; i < k; i++) begin
      id = pick_victim();
      send_word(CMD_MARK, id);
      if ($urandom_range(0, 7) == 0) send_word(CMD_MARK, id);
    end
    send_word(CMD_COLLECT, EID_W'($urandom));
    repeat ($urandom_range(0, k + 1)) send_word(CMD_ACQUIRE, EID_W'($urandom));
  endtask

  // Fill the queue past its end, then drain it.
  task automatic overflow_round();
    while (sb.release_depth < QUEUE_SLOTS) send_word(CMD_MARK, pick_victim());
    repeat ($urandom_range(1, 3)) send_word(CMD_MARK, EID_W'($urandom));
    send_word(CMD_COLLECT, '0);
  endtask

  // Release every live entry, then hand them all out and one more.
  task automatic drain_all_round();
    logic [EID_W-1:0] ids[$];
    logic [EID_W-1:0] tmp;
    int unsigned      j;
    for (int i = 0; i < sb.active_depth; i++) ids = {ids, sb.active_list[i]};
    for (int i = ids.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = ids[i];
      ids[i] = ids[j];
      ids[j] = tmp;
    end
    if (sb.release_depth != 0) send_word(CMD_COLLECT, '0);
    foreach (ids[i]) send_word(CMD_MARK, ids[i]);
    send_word(CMD_COLLECT, '1);
    repeat (sb.free_depth + 1) send_word(CMD_ACQUIRE, EID_W'($urandom));
  endtask

  initial begin
    int unsigned r;
    bit          paused;
    calm         = 1'b0;
    paused       = 1'b0;
    words_sent   = 0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    rst_ni       = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: unused code, empty pool, duplicate and stale marks, LIFO order.
    send_word(CMD_UNUSED, 6'd63);
    send_word(CMD_ACQUIRE, 6'd0);
    send_word(CMD_MARK, 6'd0);
    send_word(CMD_MARK, 6'd63);
    send_word(CMD_MARK, 6'd63);
    send_word(CMD_MARK, 6'd5);
    send_word(CMD_COLLECT, 6'd0);
    send_word(CMD_ACQUIRE, 6'd0);
    send_word(CMD_COLLECT, 6'd63);
    send_word(CMD_MARK, 6'd42);
    send_word(CMD_COLLECT, 6'd0);
    send_word(CMD_MARK, 6'd42);
    send_word(CMD_MARK, 6'd63);
    send_word(CMD_COLLECT, 6'd0);
    send_word(CMD_ACQUIRE, 6'd0);
    send_word(CMD_ACQUIRE, 6'd63);
    send_word(CMD_ACQUIRE, 6'd0);
    send_word(CMD_ACQUIRE, 6'd0);
    send_word(CMD_UNUSED, 6'd0);

    while (words_sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        release_round();
      end else if (r < 60) begin
        repeat ($urandom_range(1, 6)) send_word(CMD_ACQUIRE, EID_W'($urandom));
      end else if (r < 70) begin
        repeat ($urandom_range(1, 4))
          send_word(CMD_W'($urandom_range(0, 3)), EID_W'($urandom));
      end else if (r < 78) begin
        // Marks left hanging until some later collect.
        repeat ($urandom_range(1, 5)) send_word(CMD_MARK, pick_victim());
      end else if (r < 82) begin
        overflow_round();
      end else if (r < 85) begin
        drain_all_round();
      end else begin
        send_word(CMD_COLLECT, EID_W'($urandom));
      end
      if (!paused && words_sent > RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("[object_pool_swap_remove] OK");
    end else begin
      $display("[object_pool_swap_remove] ERROR");
    end
    $finish;
  end

endmodule
